### hw/rtl/lcd_pkg.sv
// shared types, constants and the keyword matcher step for the line command decoder
package lcd_pkg;

	localparam int MAX_LINE = 64;
	localparam int CNT_W = $clog2(MAX_LINE + 1);
	localparam int MIN_W = 7;
	localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [7:0] NUL_CHAR = 8'h00;

	// register indexes of the configuration port
	localparam logic [1:0] REG_TERMINATOR = 2'd0;
	localparam logic [1:0] REG_SKIP_FIRST = 2'd1;
	localparam logic [1:0] REG_SKIP_SECOND = 2'd2;
	localparam logic [1:0] REG_MIN_COUNT = 2'd3;

	// found flag positions
	localparam int FL_HELP = 0;
	localparam int FL_STATUS = 1;
	localparam int FL_LED = 2;
	localparam int FL_ON = 3;
	localparam int FL_OFF = 4;
	localparam int FL_TOGGLE = 5;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_HELP = 3'd1,
		CMD_STATUS = 3'd2,
		CMD_ON = 3'd3,
		CMD_OFF = 3'd4,
		CMD_TOGGLE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK = 2'd0,
		ERR_OVERFLOW = 2'd1,
		ERR_SYNTAX = 2'd2,
		ERR_UNKNOWN = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] terminator;
		logic [7:0] skip_first;
		logic [7:0] skip_second;
		logic [MIN_W-1:0] min_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0] echo;
		logic done;
		cmd_t command;
		err_t error;
	} res_t;

	// keyword bytes, first character at index 0
	typedef logic [6:0][7:0] kw_t;

	localparam kw_t KW_HELP = {8'h00, 8'h00, 8'h00, "P", "L", "E", "H"};
	localparam kw_t KW_STATUS = {8'h00, "S", "U", "T", "A", "T", "S"};
	localparam kw_t KW_LED = {8'h00, 8'h00, 8'h00, 8'h00, "D", "E", "L"};
	localparam kw_t KW_ON = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "N", "O"};
	localparam kw_t KW_OFF = {8'h00, 8'h00, 8'h00, 8'h00, "F", "F", "O"};
	localparam kw_t KW_TOGGLE = {8'h00, "E", "L", "G", "G", "O", "T"};

	localparam logic [2:0] LEN_HELP = 3'd4;
	localparam logic [2:0] LEN_STATUS = 3'd6;
	localparam logic [2:0] LEN_LED = 3'd3;
	localparam logic [2:0] LEN_ON = 3'd2;
	localparam logic [2:0] LEN_OFF = 3'd3;
	localparam logic [2:0] LEN_TOGGLE = 3'd6;

	// longest keyword prefix that ends the text after matched prefix p and then c
	function automatic logic [2:0] kw_next(input kw_t kw, input logic [2:0] len,
			input logic [2:0] p, input logic [7:0] c);
		logic [2:0] pp;
		logic [2:0] res;
		logic found;
		logic ok;
		logic [2:0] pos;
		logic [7:0] sc;
		pp = (p >= len) ? 3'd0 : p;
		res = 3'd0;
		found = 1'b0;
		ok = 1'b0;
		pos = 3'd0;
		sc = 8'h00;
		for (int k = 7; k >= 1; k--) begin
			if (!found && (k <= int'(pp) + 1)) begin
				ok = 1'b1;
				for (int j = 0; j < 7; j++) begin
					if (j < k) begin
						pos = 3'(int'(pp) + 1 - k + j);
						sc = (pos < pp) ? kw[pos] : c;
						if (kw[3'(j)] != sc) ok = 1'b0;
					end
				end
				if (ok) begin
					res = 3'(k);
					found = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

### hw/rtl/lcd_core.sv
// line state, keyword matchers and the decision made when a line closes
module lcd_core import lcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] char_in,
	input cfg_t cfg,
	output res_t res
);

	logic in_line_q, in_line_n;
	logic [CNT_W-1:0] count_q, count_n, count_inc;
	logic [2:0] help_q, help_n, help_m;
	logic [2:0] status_q, status_n, status_m;
	logic [1:0] led_q, led_n, led_m;
	logic [1:0] on_q, on_n, on_m;
	logic [1:0] off_q, off_n, off_m;
	logic [2:0] toggle_q, toggle_n, toggle_m;
	logic [5:0] flags_q, flags_n, flags_m;
	logic ended_q, ended_n, ended_m;
	logic [7:0] up;
	logic [2:0] nx_help, nx_status, nx_led, nx_on, nx_off, nx_toggle;
	logic led_before;
	logic feed;

	assign up = (char_in >= LOWER_A && char_in <= LOWER_Z) ? char_in - CASE_OFFSET : char_in;
	assign led_before = flags_q[FL_LED];

	assign nx_help = kw_next(KW_HELP, LEN_HELP, help_q, up);
	assign nx_status = kw_next(KW_STATUS, LEN_STATUS, status_q, up);
	assign nx_led = kw_next(KW_LED, LEN_LED, {1'b0, led_q}, up);
	assign nx_on = kw_next(KW_ON, LEN_ON, {1'b0, on_q}, up);
	assign nx_off = kw_next(KW_OFF, LEN_OFF, {1'b0, off_q}, up);
	assign nx_toggle = kw_next(KW_TOGGLE, LEN_TOGGLE, toggle_q, up);

	// matcher state after feeding this character as text
	always_comb begin
		help_m = help_q;
		status_m = status_q;
		led_m = led_q;
		on_m = on_q;
		off_m = off_q;
		toggle_m = toggle_q;
		flags_m = flags_q;
		ended_m = ended_q;
		if (!ended_q) begin
			if (char_in == NUL_CHAR) begin
				ended_m = 1'b1;
			end else begin
				if (!flags_q[FL_HELP]) begin
					if (nx_help >= LEN_HELP) begin
						flags_m[FL_HELP] = 1'b1;
						help_m = 3'd0;
					end else begin
						help_m = nx_help;
					end
				end
				if (!flags_q[FL_STATUS]) begin
					if (nx_status >= LEN_STATUS) begin
						flags_m[FL_STATUS] = 1'b1;
						status_m = 3'd0;
					end else begin
						status_m = nx_status;
					end
				end
				if (!flags_q[FL_LED]) begin
					if (nx_led >= LEN_LED) begin
						flags_m[FL_LED] = 1'b1;
						led_m = 2'd0;
					end else begin
						led_m = nx_led[1:0];
					end
				end
				// actions only count after a complete led
				if (led_before) begin
					if (!flags_q[FL_ON]) begin
						if (nx_on >= LEN_ON) begin
							flags_m[FL_ON] = 1'b1;
							on_m = 2'd0;
						end else begin
							on_m = nx_on[1:0];
						end
					end
					if (!flags_q[FL_OFF]) begin
						if (nx_off >= LEN_OFF) begin
							flags_m[FL_OFF] = 1'b1;
							off_m = 2'd0;
						end else begin
							off_m = nx_off[1:0];
						end
					end
					if (!flags_q[FL_TOGGLE]) begin
						if (nx_toggle >= LEN_TOGGLE) begin
							flags_m[FL_TOGGLE] = 1'b1;
							toggle_m = 3'd0;
						end else begin
							toggle_m = nx_toggle;
						end
					end
				end
			end
		end
	end

	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		res.echo = char_in;
		res.done = 1'b0;
		res.command = CMD_NONE;
		res.error = ERR_OK;
		feed = 1'b0;
		in_line_n = in_line_q;
		count_n = count_q;
		if (!in_line_q) begin
			if (char_in != cfg.terminator && char_in != cfg.skip_first
					&& char_in != cfg.skip_second) begin
				in_line_n = 1'b1;
				count_n = CNT_W'(1);
				feed = 1'b1;
			end
		end else if (char_in == cfg.terminator) begin
			res.done = 1'b1;
			in_line_n = 1'b0;
			count_n = '0;
			if (CMP_W'(count_inc) <= CMP_W'(cfg.min_count)) begin
				res.error = ERR_SYNTAX;
			end else if (flags_q[FL_HELP]) begin
				res.command = CMD_HELP;
			end else if (flags_q[FL_STATUS]) begin
				res.command = CMD_STATUS;
			end else if (!flags_q[FL_LED]) begin
				res.error = ERR_UNKNOWN;
			end else if (flags_q[FL_ON]) begin
				res.command = CMD_ON;
			end else if (flags_q[FL_OFF]) begin
				res.command = CMD_OFF;
			end else if (flags_q[FL_TOGGLE]) begin
				res.command = CMD_TOGGLE;
			end else begin
				res.error = ERR_SYNTAX;
			end
		end else if (CMP_W'(count_inc) >= CMP_W'(MAX_LINE)) begin
			res.done = 1'b1;
			res.error = ERR_OVERFLOW;
			in_line_n = 1'b0;
			count_n = '0;
		end else begin
			count_n = count_inc;
			feed = 1'b1;
		end
	end

	// a closed line clears every matcher; otherwise fed characters advance them
	always_comb begin
		help_n = help_q;
		status_n = status_q;
		led_n = led_q;
		on_n = on_q;
		off_n = off_q;
		toggle_n = toggle_q;
		flags_n = flags_q;
		ended_n = ended_q;
		if (res.done) begin
			help_n = '0;
			status_n = '0;
			led_n = '0;
			on_n = '0;
			off_n = '0;
			toggle_n = '0;
			flags_n = '0;
			ended_n = 1'b0;
		end else if (feed) begin
			help_n = help_m;
			status_n = status_m;
			led_n = led_m;
			on_n = on_m;
			off_n = off_m;
			toggle_n = toggle_m;
			flags_n = flags_m;
			ended_n = ended_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q <= 1'b0;
			count_q <= '0;
			help_q <= '0;
			status_q <= '0;
			led_q <= '0;
			on_q <= '0;
			off_q <= '0;
			toggle_q <= '0;
			flags_q <= '0;
			ended_q <= 1'b0;
		end else if (step) begin
			in_line_q <= in_line_n;
			count_q <= count_n;
			help_q <= help_n;
			status_q <= status_n;
			led_q <= led_n;
			on_q <= on_n;
			off_q <= off_n;
			toggle_q <= toggle_n;
			flags_q <= flags_n;
			ended_q <= ended_n;
		end
	end

endmodule

### hw/rtl/line_command_keyword_decoder_top.sv
// top level of the line command keyword decoder: config registers and the two-stage pipeline
//
// one received character enters per item on the in channel (in_valid, in_stall,
// rx_char) and exactly one result leaves per item on the out channel (out_valid,
// out_stall, echo_char, line_done, command, error_code), in order.
// an item is taken at a clock edge with valid high and stall low.
// the character is registered, then the line state and the keyword matchers update
// in one pass and the result is registered. one item is taken per cycle while the
// receiver does not stall. when the receiver stalls, both stages hold and in_stall
// rises as long as the result register is full and not taken, so nothing is lost or
// repeated. configuration is written through cfg_we, cfg_index and cfg_data; the
// user must do so only while idle, which the block does not enforce. reset clears
// the line state and loads terminator 13, skip characters 10 and 32 and a minimum
// count of 4; no item is taken until reset is released.
module line_command_keyword_decoder_top import lcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_char,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] echo_char,
	output logic line_done,
	output logic [2:0] command,
	output logic [1:0] error_code
);

	cfg_t cfg_q;
	logic v_s1, v_s2;
	logic [7:0] char_s1;
	res_t res_s2;
	res_t core_res;
	logic adv;

	// pipeline moves whenever the result register is free or being taken
	assign adv = !v_s2 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.terminator <= 8'd13;
			cfg_q.skip_first <= 8'd10;
			cfg_q.skip_second <= 8'd32;
			cfg_q.min_count <= MIN_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TERMINATOR: cfg_q.terminator <= cfg_data;
				REG_SKIP_FIRST: cfg_q.skip_first <= cfg_data;
				REG_SKIP_SECOND: cfg_q.skip_second <= cfg_data;
				REG_MIN_COUNT: cfg_q.min_count <= cfg_data[MIN_W-1:0];
				default: ;
			endcase
		end
	end

	lcd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(v_s1 && adv),
		.char_in(char_s1),
		.cfg(cfg_q),
		.res(core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			char_s1 <= rx_char;
		end
		if (adv && v_s1) begin
			res_s2 <= core_res;
		end
	end

	assign out_valid = v_s2;
	assign echo_char = res_s2.echo;
	assign line_done = res_s2.done;
	assign command = res_s2.command;
	assign error_code = res_s2.error;

	// a closed line carries either a command or an error, never both or neither
	a_done_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_done) |->
			((command == CMD_NONE) != (error_code == ERR_OK)))
		else $error("closed line without exactly one outcome");

	a_open_line_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !line_done) |-> (command == CMD_NONE && error_code == ERR_OK))
		else $error("command or error on a character that closed no line");

	a_echo_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> (out_valid && echo_char == $past(char_s1)))
		else $error("echoed character lost between stages");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(echo_char)
			&& $stable(line_done)))
		else $error("held result changed under stall");

endmodule

### tb/line_command_keyword_decoder_top_tb.sv
// testbench for the line command keyword decoder: command lines checked against a line predictor
`timescale 1ns / 1ps

module line_command_keyword_decoder_top_tb;
	import lcd_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_char;
	logic out_valid;
	logic out_stall;
	logic [7:0] echo_char;
	logic line_done;
	logic [2:0] command;
	logic [1:0] error_code;

	line_command_keyword_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_char(rx_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.echo_char(echo_char),
		.line_done(line_done),
		.command(command),
		.error_code(error_code)
	);

	// predictor copy of the registers
	logic [7:0] term_q;
	logic [7:0] skip1_q;
	logic [7:0] skip2_q;
	logic [6:0] minc_q;

	// predictor copy of the line state
	bit in_line;
	int line_count;
	int kw_pos [6];
	logic [5:0] found;
	bit text_done;

	// order follows the found flag positions
	string keywords [6] = '{"HELP", "STATUS", "LED", "ON", "OFF", "TOGGLE"};
	string overlap_words [11] = '{"HEHELP", "STATSTATUS", "LELED", "LEDOOFF", "TOTOGGLE",
		"LEDOON", "LEDOFON", "HELHELP", "LEDTOGTOGGLE", "STASTATUS", "LLEDOFOFF"};
	string soup = "HELPSTAUSDONFG ";
	string junk = " .,-19ABXYZelnotg";

	res_t pending_decodes [$];
	logic [7:0] line_chars [$];
	int mismatches = 0;
	int chars_sent = 0;
	bit idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (mismatches < 100)
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// longest keyword prefix that ends the text after matched prefix p and then c
	function automatic int kw_advance(string kw, int p, logic [7:0] c);
		int at;
		bit ok;
		logic [7:0] seen;
		if (p >= kw.len()) p = 0;
		for (int k = p + 1; k > 0; k--) begin
			ok = 1'b1;
			for (int j = 0; j < k; j++) begin
				at = p + 1 - k + j;
				seen = (at < p) ? kw[at] : c;
				if (kw[j] != seen) ok = 1'b0;
			end
			if (ok) return k;
		end
		return 0;
	endfunction

	function automatic void run_keyword(int idx, logic [7:0] c);
		if (found[idx]) return;
		kw_pos[idx] = kw_advance(keywords[idx], kw_pos[idx], c);
		if (kw_pos[idx] >= keywords[idx].len()) begin
			found[idx] = 1'b1;
			kw_pos[idx] = 0;
		end
	endfunction

	function automatic void match_text(logic [7:0] c);
		logic [7:0] up;
		bit led_seen;
		if (text_done) return;
		if (c == NUL_CHAR) begin
			text_done = 1'b1;
			return;
		end
		up = (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_OFFSET : c;
		// actions only count on characters after the first complete LED
		led_seen = found[FL_LED];
		run_keyword(FL_HELP, up);
		run_keyword(FL_STATUS, up);
		run_keyword(FL_LED, up);
		if (led_seen) begin
			run_keyword(FL_ON, up);
			run_keyword(FL_OFF, up);
			run_keyword(FL_TOGGLE, up);
		end
	endfunction

	function automatic void clear_line();
		in_line = 1'b0;
		line_count = 0;
		foreach (kw_pos[i]) kw_pos[i] = 0;
		found = '0;
		text_done = 1'b0;
	endfunction

	function automatic res_t decode_char(logic [7:0] c);
		res_t r;
		r.echo = c;
		r.done = 1'b0;
		r.command = CMD_NONE;
		r.error = ERR_OK;
		if (!in_line) begin
			if (c != term_q && c != skip1_q && c != skip2_q) begin
				in_line = 1'b1;
				line_count = 1;
				match_text(c);
			end
		end else begin
			line_count++;
			if (c == term_q) begin
				r.done = 1'b1;
				if (line_count <= int'(minc_q)) r.error = ERR_SYNTAX;
				else if (found[FL_HELP]) r.command = CMD_HELP;
				else if (found[FL_STATUS]) r.command = CMD_STATUS;
				else if (!found[FL_LED]) r.error = ERR_UNKNOWN;
				else if (found[FL_ON]) r.command = CMD_ON;
				else if (found[FL_OFF]) r.command = CMD_OFF;
				else if (found[FL_TOGGLE]) r.command = CMD_TOGGLE;
				else r.error = ERR_SYNTAX;
				clear_line();
			end else if (line_count >= MAX_LINE) begin
				r.done = 1'b1;
				r.error = ERR_OVERFLOW;
				clear_line();
			end else begin
				match_text(c);
			end
		end
		return r;
	endfunction

	// receiver side: random stall bursts
	initial begin
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				hold = $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("result with nothing expected", echo_char, 8'h00);
			end else begin
				want = pending_decodes.pop_front();
				if (echo_char !== want.echo) report_mismatch("echo_char", echo_char, want.echo);
				if (line_done !== want.done) report_mismatch("line_done", line_done, want.done);
				if (command !== want.command) report_mismatch("command", command, want.command);
				if (error_code !== want.error)
					report_mismatch("error_code", error_code, want.error);
			end
		end
	end

	task automatic send_char(logic [7:0] c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_char <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_decodes.push_back(decode_char(c));
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TERMINATOR: term_q = data;
			REG_SKIP_FIRST: skip1_q = data;
			REG_SKIP_SECOND: skip2_q = data;
			REG_MIN_COUNT: minc_q = data[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_config(logic [7:0] t, logic [7:0] s1, logic [7:0] s2, logic [7:0] m);
		wait_idle();
		write_reg(REG_TERMINATOR, t);
		write_reg(REG_SKIP_FIRST, s1);
		write_reg(REG_SKIP_SECOND, s2);
		write_reg(REG_MIN_COUNT, m);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_case(logic [7:0] ch);
		if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) return ch + CASE_OFFSET;
		return ch;
	endfunction

	function automatic logic [7:0] letter_char();
		return random_case(8'("A" + $urandom_range(0, 25)));
	endfunction

	function automatic void push_content(logic [7:0] ch);
		// keep well-formed lines from being cut by a printable terminator
		if (ch != term_q) line_chars.push_back(ch);
	endfunction

	function automatic void push_word(string w);
		for (int i = 0; i < w.len(); i++) push_content(random_case(w[i]));
	endfunction

	function automatic void push_junk(int lo, int hi);
		repeat ($urandom_range(lo, hi))
			push_content(junk[$urandom_range(0, junk.len() - 1)]);
	endfunction

	function automatic void build_line(bit long_line);
		int spot;
		int stop;
		line_chars.delete();
		// characters dropped while idle
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				case ($urandom_range(0, 2))
					0: line_chars.push_back(term_q);
					1: line_chars.push_back(skip1_q);
					default: line_chars.push_back(skip2_q);
				endcase
		case ($urandom_range(0, 9))
			0: begin
				push_junk(0, 3);
				push_word(keywords[FL_HELP]);
				push_junk(0, 3);
			end
			1: begin
				push_junk(0, 3);
				push_word(keywords[FL_STATUS]);
				push_junk(0, 3);
			end
			2, 3: begin
				push_junk(0, 2);
				push_word(keywords[FL_LED]);
				push_junk(0, 2);
				push_word(keywords[$urandom_range(FL_ON, FL_TOGGLE)]);
				push_junk(0, 2);
			end
			4: begin
				// action ahead of the LED does not count
				push_word(keywords[$urandom_range(FL_ON, FL_TOGGLE)]);
				push_junk(0, 2);
				push_word(keywords[FL_LED]);
				if ($urandom_range(0, 1) == 1) push_word(keywords[$urandom_range(FL_ON, FL_TOGGLE)]);
			end
			5: push_word(overlap_words[$urandom_range(0, 10)]);
			6: repeat ($urandom_range(1, 10)) push_content(random_case(soup[$urandom_range(0, 14)]));
			7: begin
				push_word(keywords[FL_LED]);
				push_junk(0, 4);
			end
			8: repeat ($urandom_range(2, 3)) begin
				push_word(keywords[$urandom_range(FL_HELP, FL_TOGGLE)]);
				push_junk(0, 1);
			end
			default: repeat ($urandom_range(1, 12)) line_chars.push_back(8'($urandom_range(0, 255)));
		endcase
		if ($urandom_range(0, 9) == 0) begin
			spot = $urandom_range(0, line_chars.size());
			line_chars.insert(spot, NUL_CHAR);
		end
		if (long_line) begin
			stop = $urandom_range(MAX_LINE - 4, MAX_LINE + 2);
			while (line_chars.size() < stop) push_content(letter_char());
		end
		// an unterminated line runs on into the next one
		if ($urandom_range(0, 15) != 0) line_chars.push_back(term_q);
	endfunction

	task automatic run_lines(int count, int long_pct);
		int target;
		target = chars_sent + count;
		while (chars_sent < target) begin
			build_line($urandom_range(0, 99) < long_pct);
			foreach (line_chars[i]) send_char(line_chars[i]);
		end
	endtask

	task automatic test_directed_commands();
		send_char(skip1_q);
		send_char(skip2_q);
		send_char(term_q);
		send_text("help");
		send_char(term_q);
		send_text("STATUS");
		send_char(term_q);
		send_text("LEDon");
		send_char(term_q);
		send_text("LedToggle");
		send_char(term_q);
		send_char(LOWER_A);
		send_char(8'hFF);
		send_char(LOWER_Z);
		send_char(8'h7B);
		send_char(term_q);
		// zero byte cuts the keyword
		send_text("HE");
		send_char(NUL_CHAR);
		send_text("LP");
		send_char(term_q);
		send_text("LED");
		send_char(term_q);
	endtask

	task automatic test_line_limits();
		repeat (MAX_LINE - 1) send_char(letter_char());
		send_char(term_q);
		send_text("HELP");
		repeat (MAX_LINE - 4) send_char(letter_char());
		send_char(term_q);
		send_text("LEDOFF");
		repeat (MAX_LINE - 7) send_char(letter_char());
		send_char(term_q);
		run_lines(150, 50);
	endtask

	task automatic test_register_extremes();
		apply_config(8'h00, 8'h00, 8'h00, 8'h00);
		run_lines(110, 5);
		apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_lines(110, 5);
		// terminator shared with a skip character, every line too short
		apply_config(8'd13, 8'd13, 8'd10, 8'(MAX_LINE));
		run_lines(110, 10);
		apply_config(".", " ", " ", 8'h83);
		run_lines(110, 5);
		apply_config(8'd13, 8'd10, 8'd32, 8'hC0);
		run_lines(110, 10);
	endtask

	task automatic test_random_lines();
		apply_config(8'd13, 8'd10, 8'd32, 8'd4);
		run_lines(600, 3);
		repeat (3) begin
			apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 10)));
			run_lines(100, 3);
		end
	endtask

	task automatic test_quiet_finish();
		idle_on = 1'b0;
		apply_config(8'd13, 8'd10, 8'd32, 8'd4);
		run_lines(150, 3);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TERMINATOR;
		cfg_data <= 8'h00;
		in_valid <= 1'b0;
		rx_char <= 8'h00;
		term_q = 8'd13;
		skip1_q = 8'd10;
		skip2_q = 8'd32;
		minc_q = 7'd4;
		clear_line();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_line_limits();
		test_register_extremes();
		test_random_lines();
		test_quiet_finish();
		in_valid <= 1'b0;
		for (int n = 0; n < 1000 && pending_decodes.size() != 0; n++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_decodes.size() != 0)
			report_mismatch("results never arrived", 8'(pending_decodes.size()), 8'h00);
		if (mismatches == 0)
			$display("line_command_keyword_decoder_top_tb: PASS");
		else
			$display("line_command_keyword_decoder_top_tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("line_command_keyword_decoder_top_tb: FAIL");
		$finish;
	end

endmodule
